/* rtl/core/reserve_region_best_fit_allocator_macros.svh */
// assertion macros for the reserve region best-fit allocator
// used by reserve_region_best_fit_allocator.sv; needs no other file
`ifndef RESERVE_REGION_BEST_FIT_ALLOCATOR_MACROS_SVH
`define RESERVE_REGION_BEST_FIT_ALLOCATOR_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define RRBF_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("rrbf assertion failed");
// next-cycle implication
`define RRBF_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("rrbf assertion failed");
`else
`define RRBF_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define RRBF_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

/* rtl/core/rrbf_pkg.sv */
// shared types, constants and helpers of the reserve region best-fit allocator
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rrbf_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W = $clog2(ENTRIES);
    localparam logic [31:0] BOOTSTRAP_BYTES = 32'(1024 * 16);
    localparam logic [16:0] PAGE_BYTES_RST = 17'd4096;
    localparam logic [31:0] REFILL_THRESHOLD_RST = 32'd16384;

    typedef enum logic {
        MODE_ALLOC = 1'b0,
        MODE_ADD   = 1'b1
    } mode_t;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_NO_FIT  = 2'd1,
        STATUS_FULL    = 2'd2,
        STATUS_UNUSED  = 2'd3
    } status_t;

    typedef enum logic {
        CFG_PAGE_BYTES       = 1'b0,
        CFG_REFILL_THRESHOLD = 1'b1
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    // word that walks down the cell chain
    typedef struct packed {
        logic              valid;
        mode_t             mode;
        logic [31:0]       req;
        logic              found;
        logic [IDX_W-1:0]  pick_idx;
        logic [31:0]       pick_bytes;
        logic [31:0]       pick_start;
        logic [31:0]       max_other;
    } scan_word_t;

    // write of one region, broadcast to all cells
    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  idx;
        logic [31:0]       start;
        logic [31:0]       bytes;
        logic              live;
    } region_upd_t;

    function automatic logic [31:0] max32(input logic [31:0] a, input logic [31:0] b);
        return (a > b) ? a : b;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/reserve_region_best_fit_allocator.sv */
// top level of the reserve region best-fit allocator: cell chain, control and result register
// uses rrbf_pkg, rrbf_cell and reserve_region_best_fit_allocator_macros.svh
//
// channel   direction  payload
// s_*       in         tdata: req_size[31:0], region_base[63:32]; tuser: mode
// m_*       out        tdata: status[1:0], grant_address[33:2], refill_wanted[34], zero pad
// cfg_*     in         write: index 0 page_bytes, index 1 refill_threshold
//
// an item walks its scan word through the cells of the chain in order, then the tail word
// is latched, and the finish step writes the table and result.
// one item at a time: s_tready is high only while no item is in the chain.
// a result held by a stalled m_tready blocks the finish step and thus the next item.
// after reset: entry 0 live with the bootstrap size, registers at their defaults.
`timescale 1ns / 1ps
`default_nettype none

`include "reserve_region_best_fit_allocator_macros.svh"

module reserve_region_best_fit_allocator (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [63:0] s_tdata,   // req_size[31:0], region_base[63:32]
    input  wire         s_tuser,   // mode
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [39:0] m_tdata,   // status[1:0], grant_address[33:2], refill_wanted[34]
    input  wire         cfg_wr_en,
    input  wire  [0:0]  cfg_wr_index,
    input  wire  [31:0] cfg_wr_data
);
    import rrbf_pkg::*;

    state_t      state_reg;
    state_t      state_next;
    logic [16:0] page_bytes_reg;
    logic [31:0] refill_threshold_reg;
    scan_word_t  final_reg;
    logic        m_tvalid_reg;
    logic [39:0] m_tdata_reg;
    logic [39:0] m_tdata_next;

    scan_word_t  words [ENTRIES+1];
    logic [ENTRIES-1:0] cell_valid;
    region_upd_t upd;

    logic        s_accept;
    logic        out_free;
    logic        finish_go;

    logic [31:0] new_bytes;
    logic        new_live;
    logic [31:0] largest;
    status_t     status;
    logic [31:0] grant;

    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // launch word into the head of the chain
    always_comb begin
        words[0].valid      = s_accept;
        words[0].mode       = mode_t'(s_tuser);
        words[0].req        = s_tdata[31:0];
        words[0].found      = 1'b0;
        words[0].pick_idx   = '0;
        words[0].pick_bytes = '0;
        words[0].pick_start = s_tdata[63:32];
        words[0].max_other  = '0;
    end

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        rrbf_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .cell_idx (IDX_W'(g)),
            .word_in  (words[g]),
            .word_out (words[g+1]),
            .upd      (upd)
        );
        assign cell_valid[g] = words[g+1].valid;
    end

    // region base of an add rides in pick_start until a slot is found, so keep a copy
    logic [31:0] add_base_reg;
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            add_base_reg <= s_tdata[63:32];
        end
    end

    always_ff @(posedge aclk) begin
        if (words[ENTRIES].valid) begin
            final_reg <= words[ENTRIES];
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (s_accept) state_next = ST_SCAN;
            ST_SCAN:   if (words[ENTRIES].valid) state_next = ST_FINISH;
            ST_FINISH: if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        s_tready  = (state_reg == ST_IDLE);
        finish_go = (state_reg == ST_FINISH) && out_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // finish step: table write and result word
    always_comb begin
        new_bytes = final_reg.pick_bytes - final_reg.req;
        new_live  = (new_bytes >= {15'd0, page_bytes_reg});
        upd.en    = finish_go && final_reg.found;
        upd.idx   = final_reg.pick_idx;
        status    = STATUS_OK;
        grant     = '0;
        largest   = final_reg.max_other;
        if (final_reg.mode == MODE_ALLOC) begin
            upd.start = final_reg.pick_start + final_reg.req;
            upd.bytes = new_bytes;
            upd.live  = new_live;
            if (final_reg.found) begin
                grant = final_reg.pick_start;
                if (new_live) begin
                    largest = max32(final_reg.max_other, new_bytes);
                end
            end else begin
                status = STATUS_NO_FIT;
            end
        end else begin
            upd.start = add_base_reg;
            upd.bytes = final_reg.req;
            upd.live  = 1'b1;
            if (final_reg.found) begin
                largest = max32(final_reg.max_other, final_reg.req);
            end else begin
                status = STATUS_FULL;
            end
        end
        m_tdata_next = {5'd0, (largest < refill_threshold_reg), grant, status};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (finish_go) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (finish_go) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            page_bytes_reg       <= PAGE_BYTES_RST;
            refill_threshold_reg <= REFILL_THRESHOLD_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index_t'(cfg_wr_index))
                CFG_PAGE_BYTES:       page_bytes_reg       <= cfg_wr_data[16:0];
                CFG_REFILL_THRESHOLD: refill_threshold_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // only one word in the chain at a time
    `RRBF_ASSERT_IMPL(a_one_word, aclk, aresetn, 1'b1, $onehot0(cell_valid))
    // an accepted word shows up in the first cell
    `RRBF_ASSERT_NEXT(a_launch, aclk, aresetn, s_accept, cell_valid[0])
    // the tail word always leads to the finish step
    `RRBF_ASSERT_NEXT(a_tail_finish, aclk, aresetn, words[ENTRIES].valid,
                      state_reg == ST_FINISH)
    // the table is written only in the finish step
    `RRBF_ASSERT_IMPL(a_upd_finish, aclk, aresetn, upd.en, state_reg == ST_FINISH)
    // no word may enter while one is still in the chain
    `RRBF_ASSERT_IMPL(a_no_overlap, aclk, aresetn, s_tready, cell_valid == '0)

endmodule

`default_nettype wire

/* rtl/core/rrbf_cell.sv */
// one table slot of the allocator: holds base, size and live mark of a region
// and folds its region into the scan word passing through; uses rrbf_pkg
`timescale 1ns / 1ps
`default_nettype none

module rrbf_cell (
    input  wire                       aclk,
    input  wire                       aresetn,
    input  wire [rrbf_pkg::IDX_W-1:0] cell_idx,
    input  rrbf_pkg::scan_word_t      word_in,
    output rrbf_pkg::scan_word_t      word_out,
    input  rrbf_pkg::region_upd_t     upd
);
    import rrbf_pkg::*;

    logic [31:0] start_reg;
    logic [31:0] bytes_reg;
    logic        live_reg;
    scan_word_t  word_reg;
    scan_word_t  word_next;

    logic fits;
    logic better;

    always_comb begin
        word_next = word_in;
        fits   = live_reg && (bytes_reg >= word_in.req);
        better = fits && (!word_in.found || (bytes_reg < word_in.pick_bytes));
        unique case (word_in.mode)
            MODE_ALLOC: begin
                if (better) begin
                    // displaced candidate joins the others
                    if (word_in.found) begin
                        word_next.max_other = max32(word_in.max_other, word_in.pick_bytes);
                    end
                    word_next.found      = 1'b1;
                    word_next.pick_idx   = cell_idx;
                    word_next.pick_bytes = bytes_reg;
                    word_next.pick_start = start_reg;
                end else if (live_reg) begin
                    word_next.max_other = max32(word_in.max_other, bytes_reg);
                end
            end
            MODE_ADD: begin
                if (!live_reg && !word_in.found) begin
                    word_next.found      = 1'b1;
                    word_next.pick_idx   = cell_idx;
                    word_next.pick_bytes = bytes_reg;
                    word_next.pick_start = start_reg;
                end else if (live_reg) begin
                    word_next.max_other = max32(word_in.max_other, bytes_reg);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            word_reg.valid <= 1'b0;
        end else begin
            word_reg.valid <= word_in.valid;
        end
        word_reg.mode       <= word_next.mode;
        word_reg.req        <= word_next.req;
        word_reg.found      <= word_next.found;
        word_reg.pick_idx   <= word_next.pick_idx;
        word_reg.pick_bytes <= word_next.pick_bytes;
        word_reg.pick_start <= word_next.pick_start;
        word_reg.max_other  <= word_next.max_other;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg <= '0;
            bytes_reg <= (cell_idx == '0) ? BOOTSTRAP_BYTES : '0;
            live_reg  <= (cell_idx == '0);
        end else if (upd.en && (upd.idx == cell_idx)) begin
            start_reg <= upd.start;
            bytes_reg <= upd.bytes;
            live_reg  <= upd.live;
        end
    end

    assign word_out = word_reg;

endmodule

`default_nettype wire
